FILE: hdl/coo2hg_pkg.sv
// coo2hg_pkg: shared constants, codes and controller/datapath types for the
// COO to hypergraph CSR builder. No dependencies.
package coo2hg_pkg;

  // Sizing defaults
  localparam int MAX_NONZEROS   = 1024;
  localparam int MAX_HYPEREDGES = 1024;
  localparam int MAX_MODES      = 4;
  localparam int MODE_W         = 2;
  localparam int INDEX_BITS     = 10;

  // Field widths
  localparam int OP_W      = 2;
  localparam int IDX_W     = 12;
  localparam int VALUE_W   = 13;
  localparam int STATUS_W  = 3;
  localparam int SIZE_W    = 11;
  localparam int MC_W      = 3;
  localparam int SUM_W     = 13;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REGIDX_W  = 3;

  // Register indexes
  localparam logic [REGIDX_W-1:0] REG_MODE_COUNT = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_MODE0_SIZE = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_MODE1_SIZE = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_MODE2_SIZE = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_MODE3_SIZE = 3'd4;

  localparam logic [MC_W-1:0] MODE_COUNT_RESET = 3'd3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_BUILD   = 2'd1,
    OP_RD_OFF  = 2'd2,
    OP_RD_LIST = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_COORD    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BAD_READ = 3'd3,
    ST_TOO_MANY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_CONN = 2'd1,
    RES_OFF  = 2'd2,
    RES_LIST = 2'd3
  } res_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHK_RD,
    S_CHK_EVAL,
    S_CLR,
    S_CNT_RD,
    S_CNT_ADDR,
    S_CNT_WR,
    S_PFX_RD,
    S_PFX_WR,
    S_SC_RD,
    S_SC_ADDR,
    S_SC_WR,
    S_COMMIT,
    S_RESP
  } fsm_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     do_load;
    logic     clr_built;
    logic     init_walk;
    logic     step_n;
    logic     step_nm;
    logic     step_h;
    logic     coord_rd;
    logic     cnt_clr;
    logic     cnt_rd_inc;
    logic     cnt_wr_inc;
    logic     pfx_rd;
    logic     pfx_wr;
    logic     cnt_rd_e;
    logic     scat_wr;
    logic     commit;
    logic     off_rd;
    logic     list_rd;
    logic     set_res;
    res_src_t res_src;
    status_t  res_status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic full;
    logic load_bad;
    logic too_many;
    logic row_bad;
    logic last_n;
    logic last_nm;
    logic h_last;
    logic nz_zero;
    logic off_ok;
    logic list_ok;
    logic built;
  } dp_stat_t;

endpackage

FILE: hdl/coo2hg_if.sv
// coo2hg_if: request and result channels (valid/ready plus payload) of the CSR builder.
// Depends on coo2hg_pkg for field widths.
interface coo2hg_in_if;
  logic                            valid;
  logic                            ready;
  logic [coo2hg_pkg::OP_W-1:0]       opcode;
  logic [coo2hg_pkg::INDEX_BITS-1:0] coord0;
  logic [coo2hg_pkg::INDEX_BITS-1:0] coord1;
  logic [coo2hg_pkg::INDEX_BITS-1:0] coord2;
  logic [coo2hg_pkg::INDEX_BITS-1:0] coord3;
  logic [coo2hg_pkg::IDX_W-1:0]      read_index;

  modport source (output valid, opcode, coord0, coord1, coord2, coord3, read_index,
                  input ready);
  modport sink   (input valid, opcode, coord0, coord1, coord2, coord3, read_index,
                  output ready);
endinterface

interface coo2hg_out_if;
  logic                          valid;
  logic                          ready;
  logic [coo2hg_pkg::VALUE_W-1:0]  value;
  logic [coo2hg_pkg::STATUS_W-1:0] status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

FILE: hdl/coo2hg_ctrl.sv
// coo2hg_ctrl: sequencing state machine of the CSR builder.
// Depends on coo2hg_pkg; drives coo2hg_dp through cmd_t, reads dp_stat_t.
module coo2hg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_free,
  output logic                  res_valid,
  input  coo2hg_pkg::dp_stat_t  stat,
  output coo2hg_pkg::cmd_t      cmd
);

  coo2hg_pkg::fsm_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= coo2hg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_src    = coo2hg_pkg::RES_ZERO;
    cmd.res_status = coo2hg_pkg::ST_OK;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    case (state_r)
      coo2hg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = coo2hg_pkg::S_DISPATCH;
        end
      end
      coo2hg_pkg::S_DISPATCH: begin
        case (stat.op)
          coo2hg_pkg::OP_LOAD: begin
            cmd.set_res = 1'b1;
            if (stat.full) begin
              cmd.res_status = coo2hg_pkg::ST_FULL;
            end else if (stat.load_bad) begin
              cmd.res_status = coo2hg_pkg::ST_COORD;
            end else begin
              cmd.do_load = 1'b1;
            end
            state_nxt = coo2hg_pkg::S_RESP;
          end
          coo2hg_pkg::OP_BUILD: begin
            cmd.clr_built = 1'b1;
            if (stat.too_many) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = coo2hg_pkg::ST_TOO_MANY;
              state_nxt      = coo2hg_pkg::S_RESP;
            end else begin
              cmd.init_walk = 1'b1;
              state_nxt = stat.nz_zero ? coo2hg_pkg::S_CLR : coo2hg_pkg::S_CHK_RD;
            end
          end
          coo2hg_pkg::OP_RD_OFF: begin
            cmd.set_res = 1'b1;
            if (stat.off_ok) begin
              cmd.off_rd  = 1'b1;
              cmd.res_src = coo2hg_pkg::RES_OFF;
            end else begin
              cmd.res_status = coo2hg_pkg::ST_BAD_READ;
            end
            state_nxt = coo2hg_pkg::S_RESP;
          end
          default: begin
            cmd.set_res = 1'b1;
            if (stat.list_ok) begin
              cmd.list_rd = 1'b1;
              cmd.res_src = coo2hg_pkg::RES_LIST;
            end else begin
              cmd.res_status = coo2hg_pkg::ST_BAD_READ;
            end
            state_nxt = coo2hg_pkg::S_RESP;
          end
        endcase
      end
      // Recheck stored coordinates against current sizes
      coo2hg_pkg::S_CHK_RD: begin
        cmd.coord_rd = 1'b1;
        state_nxt    = coo2hg_pkg::S_CHK_EVAL;
      end
      coo2hg_pkg::S_CHK_EVAL: begin
        if (stat.row_bad) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = coo2hg_pkg::ST_COORD;
          state_nxt      = coo2hg_pkg::S_RESP;
        end else if (stat.last_n) begin
          cmd.init_walk = 1'b1;
          state_nxt     = coo2hg_pkg::S_CLR;
        end else begin
          cmd.step_n = 1'b1;
          state_nxt  = coo2hg_pkg::S_CHK_RD;
        end
      end
      // Clear counters
      coo2hg_pkg::S_CLR: begin
        cmd.cnt_clr = 1'b1;
        if (stat.h_last) begin
          cmd.init_walk = 1'b1;
          state_nxt = stat.nz_zero ? coo2hg_pkg::S_PFX_RD : coo2hg_pkg::S_CNT_RD;
        end else begin
          cmd.step_h = 1'b1;
        end
      end
      // Count members per hyperedge
      coo2hg_pkg::S_CNT_RD: begin
        cmd.coord_rd = 1'b1;
        state_nxt    = coo2hg_pkg::S_CNT_ADDR;
      end
      coo2hg_pkg::S_CNT_ADDR: begin
        cmd.cnt_rd_inc = 1'b1;
        state_nxt      = coo2hg_pkg::S_CNT_WR;
      end
      coo2hg_pkg::S_CNT_WR: begin
        cmd.cnt_wr_inc = 1'b1;
        if (stat.last_nm) begin
          cmd.init_walk = 1'b1;
          state_nxt     = coo2hg_pkg::S_PFX_RD;
        end else begin
          cmd.step_nm = 1'b1;
          state_nxt   = coo2hg_pkg::S_CNT_RD;
        end
      end
      // Running sum into offsets and cursors
      coo2hg_pkg::S_PFX_RD: begin
        cmd.pfx_rd = 1'b1;
        state_nxt  = coo2hg_pkg::S_PFX_WR;
      end
      coo2hg_pkg::S_PFX_WR: begin
        cmd.pfx_wr = 1'b1;
        if (stat.h_last) begin
          cmd.init_walk = 1'b1;
          state_nxt = stat.nz_zero ? coo2hg_pkg::S_COMMIT : coo2hg_pkg::S_SC_RD;
        end else begin
          cmd.step_h = 1'b1;
          state_nxt  = coo2hg_pkg::S_PFX_RD;
        end
      end
      // Scatter nonzero ids
      coo2hg_pkg::S_SC_RD: begin
        cmd.coord_rd = 1'b1;
        state_nxt    = coo2hg_pkg::S_SC_ADDR;
      end
      coo2hg_pkg::S_SC_ADDR: begin
        cmd.cnt_rd_e = 1'b1;
        state_nxt    = coo2hg_pkg::S_SC_WR;
      end
      coo2hg_pkg::S_SC_WR: begin
        cmd.scat_wr = 1'b1;
        if (stat.last_nm) begin
          state_nxt = coo2hg_pkg::S_COMMIT;
        end else begin
          cmd.step_nm = 1'b1;
          state_nxt   = coo2hg_pkg::S_SC_RD;
        end
      end
      coo2hg_pkg::S_COMMIT: begin
        cmd.commit  = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res_src = coo2hg_pkg::RES_CONN;
        state_nxt   = coo2hg_pkg::S_RESP;
      end
      coo2hg_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_nxt = coo2hg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = coo2hg_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/coo2hg_dp.sv
// coo2hg_dp: stores, walk counters and result selection of the CSR builder.
// Depends on coo2hg_pkg; commanded by coo2hg_ctrl.
module coo2hg_dp #(
  parameter int MAX_NONZEROS   = coo2hg_pkg::MAX_NONZEROS,
  parameter int MAX_HYPEREDGES = coo2hg_pkg::MAX_HYPEREDGES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  coo2hg_pkg::cmd_t                    cmd,
  output coo2hg_pkg::dp_stat_t                stat,
  input  logic [coo2hg_pkg::MC_W-1:0]         modes,
  input  logic [coo2hg_pkg::SIZE_W-1:0]       size [coo2hg_pkg::MAX_MODES],
  input  logic [coo2hg_pkg::OP_W-1:0]         in_opcode,
  input  logic [coo2hg_pkg::INDEX_BITS-1:0]   in_coord [coo2hg_pkg::MAX_MODES],
  input  logic [coo2hg_pkg::IDX_W-1:0]        in_read_index,
  output logic [coo2hg_pkg::VALUE_W-1:0]      res_value,
  output logic [coo2hg_pkg::STATUS_W-1:0]     res_status
);

  localparam int CB    = coo2hg_pkg::INDEX_BITS;
  localparam int NM    = coo2hg_pkg::MAX_MODES;
  localparam int SLOTS = MAX_NONZEROS * NM;
  localparam int NA    = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int NCW   = $clog2(MAX_NONZEROS + 1);
  localparam int HA    = (MAX_HYPEREDGES > 0) ? $clog2(MAX_HYPEREDGES + 1) : 1;
  localparam int LA    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int SW    = coo2hg_pkg::SUM_W;
  localparam int RW    = NM * CB;

  // Captured request
  coo2hg_pkg::op_t             op_r;
  logic [CB-1:0]               crd_r [NM];
  logic [coo2hg_pkg::IDX_W-1:0] idx_r;

  // Build state
  logic [NCW-1:0] nz_r;
  logic           built_r;
  logic [SW-1:0]  bhe_r;
  logic [CW-1:0]  bconn_r;

  // Walk counters
  logic [NA-1:0]               n_r;
  logic [coo2hg_pkg::MODE_W-1:0] m_r;
  logic [SW-1:0]               base_r;
  logic [HA-1:0]               h_r;
  logic [CW-1:0]               acc_r;
  logic [HA-1:0]               cnt_addr_r;

  // Memories
  logic [RW-1:0] crd_mem  [MAX_NONZEROS];
  logic [CW-1:0] cnt_mem  [MAX_HYPEREDGES + 1];
  logic [CW-1:0] off_mem  [MAX_HYPEREDGES + 1];
  logic [NA-1:0] list_mem [SLOTS];
  logic [RW-1:0] row_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] off_q;
  logic [NA-1:0] list_q;

  coo2hg_pkg::res_src_t res_src_r;
  coo2hg_pkg::status_t  res_stat_r;

  logic [SW-1:0]  total;
  logic [RW-1:0]  row_wd;
  logic           load_bad;
  logic           row_bad;
  logic [SW-1:0]  edge_id;
  logic [CW-1:0]  acc_nxt;
  logic           cnt_we;
  logic [HA-1:0]  cnt_wa;
  logic [CW-1:0]  cnt_wd;
  logic           cnt_re;
  logic [HA-1:0]  cnt_ra;

  // Size sum and coordinate range checks
  always_comb begin
    total    = '0;
    load_bad = 1'b0;
    row_bad  = 1'b0;
    row_wd   = '0;
    for (int m = 0; m < NM; m++) begin
      row_wd[m*CB +: CB] = crd_r[m];
      if (m < int'(modes)) begin
        total = total + SW'(size[m]);
        if (SW'(crd_r[m]) >= SW'(size[m])) load_bad = 1'b1;
        if (SW'(row_q[m*CB +: CB]) >= SW'(size[m])) row_bad = 1'b1;
      end
    end
  end

  assign edge_id = base_r + SW'(row_q[m_r*CB +: CB]);
  assign acc_nxt = acc_r + cnt_q;

  // Status to controller
  always_comb begin
    stat.op       = op_r;
    stat.full     = (nz_r == NCW'(MAX_NONZEROS));
    stat.load_bad = load_bad;
    stat.too_many = (32'(total) > MAX_HYPEREDGES);
    stat.row_bad  = row_bad;
    stat.last_n   = ((NCW'(n_r) + NCW'(1)) == nz_r);
    stat.last_nm  = stat.last_n && ((coo2hg_pkg::MC_W'(m_r) + 3'd1) == modes);
    stat.h_last   = (SW'(h_r) == total);
    stat.nz_zero  = (nz_r == '0);
    stat.off_ok   = built_r && (SW'(idx_r) <= bhe_r) && (32'(idx_r) <= MAX_HYPEREDGES);
    stat.list_ok  = built_r && (32'(idx_r) < 32'(bconn_r)) && (32'(idx_r) < SLOTS);
    stat.built    = built_r;
  end

  // Request capture, counts and walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r    <= '0;
      built_r <= 1'b0;
      bhe_r   <= '0;
      bconn_r <= '0;
    end else begin
      if (cmd.do_load) begin
        nz_r    <= nz_r + NCW'(1);
        built_r <= 1'b0;
      end
      if (cmd.clr_built) built_r <= 1'b0;
      if (cmd.commit) begin
        built_r <= 1'b1;
        bhe_r   <= total;
        bconn_r <= CW'(nz_r) * CW'(modes);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= coo2hg_pkg::op_t'(in_opcode);
      crd_r <= in_coord;
      idx_r <= in_read_index;
    end
    if (cmd.set_res) begin
      res_src_r  <= cmd.res_src;
      res_stat_r <= cmd.res_status;
    end
    if (cmd.pfx_wr && !cmd.init_walk) acc_r <= acc_nxt;
    if (cmd.step_n) n_r <= n_r + NA'(1);
    if (cmd.step_h) h_r <= h_r + HA'(1);
    if (cmd.step_nm) begin
      if (stat.last_n) begin
        n_r    <= '0;
        m_r    <= m_r + coo2hg_pkg::MODE_W'(1);
        base_r <= base_r + SW'(size[m_r]);
      end else begin
        n_r <= n_r + NA'(1);
      end
    end
    if (cmd.init_walk) begin
      n_r    <= '0;
      m_r    <= '0;
      base_r <= '0;
      h_r    <= '0;
      acc_r  <= '0;
    end
    if (cmd.cnt_rd_inc || cmd.cnt_rd_e) cnt_addr_r <= cnt_ra;
  end

  // Coordinate store: one row per nonzero
  always_ff @(posedge clk) begin
    if (cmd.do_load) crd_mem[nz_r[NA-1:0]] <= row_wd;
    if (cmd.coord_rd) row_q <= crd_mem[n_r];
  end

  // Counter / cursor store port selection
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = h_r;
    cnt_wd = '0;
    if (cmd.cnt_clr) begin
      cnt_we = 1'b1;
    end else if (cmd.pfx_wr) begin
      cnt_we = 1'b1;
      cnt_wd = acc_nxt;
    end else if (cmd.cnt_wr_inc || cmd.scat_wr) begin
      cnt_we = 1'b1;
      cnt_wa = cnt_addr_r;
      cnt_wd = cnt_q + CW'(1);
    end
    cnt_re = cmd.cnt_rd_inc || cmd.cnt_rd_e || cmd.pfx_rd;
    cnt_ra = h_r;
    if (cmd.cnt_rd_inc) cnt_ra = HA'(edge_id + SW'(1));
    else if (cmd.cnt_rd_e) cnt_ra = HA'(edge_id);
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_q <= cnt_mem[cnt_ra];
  end

  // Offset store
  always_ff @(posedge clk) begin
    if (cmd.pfx_wr) off_mem[h_r] <= acc_nxt;
    if (cmd.off_rd) off_q <= off_mem[HA'(idx_r)];
  end

  // Member list store
  always_ff @(posedge clk) begin
    if (cmd.scat_wr && (32'(cnt_q) < SLOTS)) list_mem[LA'(cnt_q)] <= n_r;
    if (cmd.list_rd) list_q <= list_mem[LA'(idx_r)];
  end

  // Result selection
  always_comb begin
    case (res_src_r)
      coo2hg_pkg::RES_CONN: res_value = coo2hg_pkg::VALUE_W'(bconn_r);
      coo2hg_pkg::RES_OFF:  res_value = coo2hg_pkg::VALUE_W'(off_q);
      coo2hg_pkg::RES_LIST: res_value = coo2hg_pkg::VALUE_W'(list_q);
      default:              res_value = '0;
    endcase
  end
  assign res_status = res_stat_r;

endmodule

FILE: hdl/coo_to_hypergraph_csr.sv
// coo_to_hypergraph_csr: top level; configuration registers, output register,
// controller and datapath. Depends on coo2hg_pkg, coo2hg_if, coo2hg_ctrl, coo2hg_dp.
// Load and read: the request is captured, dispatched and answered via the output register;
// the next request waits until the result has entered the output register. A good build
// rechecks coordinates, clears counters, counts, sums, scatters; the next request waits.
// Reset (synchronous, rst_n low): no nonzeros, nothing built, mode count 3, sizes 0.
module coo_to_hypergraph_csr #(
  parameter int MAX_NONZEROS   = coo2hg_pkg::MAX_NONZEROS,
  parameter int MAX_HYPEREDGES = coo2hg_pkg::MAX_HYPEREDGES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  coo2hg_in_if.sink                         in_chan,
  coo2hg_out_if.source                      out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [coo2hg_pkg::PADDR_W-1:0]    paddr,
  input  logic [coo2hg_pkg::PDATA_W-1:0]    pwdata,
  output logic [coo2hg_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int NM = coo2hg_pkg::MAX_MODES;

  logic [coo2hg_pkg::MC_W-1:0]   mode_count_r;
  logic [coo2hg_pkg::SIZE_W-1:0] size_r [NM];
  logic [coo2hg_pkg::MC_W-1:0]   modes_act;
  logic [coo2hg_pkg::REGIDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  coo2hg_pkg::cmd_t     cmd;
  coo2hg_pkg::dp_stat_t stat;
  logic                 res_valid;
  logic                 out_free;
  logic [coo2hg_pkg::VALUE_W-1:0]  res_value;
  logic [coo2hg_pkg::STATUS_W-1:0] res_status;
  logic                            out_valid_r;
  logic [coo2hg_pkg::VALUE_W-1:0]  out_value_r;
  logic [coo2hg_pkg::STATUS_W-1:0] out_status_r;
  logic [coo2hg_pkg::INDEX_BITS-1:0] in_coord [NM];

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[coo2hg_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_count_r <= coo2hg_pkg::MODE_COUNT_RESET;
      size_r       <= '{default: '0};
    end else if (cfg_wr) begin
      case (reg_idx)
        coo2hg_pkg::REG_MODE_COUNT: mode_count_r <= pwdata[coo2hg_pkg::MC_W-1:0];
        coo2hg_pkg::REG_MODE0_SIZE: size_r[0] <= pwdata[coo2hg_pkg::SIZE_W-1:0];
        coo2hg_pkg::REG_MODE1_SIZE: size_r[1] <= pwdata[coo2hg_pkg::SIZE_W-1:0];
        coo2hg_pkg::REG_MODE2_SIZE: size_r[2] <= pwdata[coo2hg_pkg::SIZE_W-1:0];
        coo2hg_pkg::REG_MODE3_SIZE: size_r[3] <= pwdata[coo2hg_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      coo2hg_pkg::REG_MODE_COUNT: prdata = coo2hg_pkg::PDATA_W'(mode_count_r);
      coo2hg_pkg::REG_MODE0_SIZE: prdata = coo2hg_pkg::PDATA_W'(size_r[0]);
      coo2hg_pkg::REG_MODE1_SIZE: prdata = coo2hg_pkg::PDATA_W'(size_r[1]);
      coo2hg_pkg::REG_MODE2_SIZE: prdata = coo2hg_pkg::PDATA_W'(size_r[2]);
      coo2hg_pkg::REG_MODE3_SIZE: prdata = coo2hg_pkg::PDATA_W'(size_r[3]);
      default:                    prdata = '0;
    endcase
  end

  // Active mode count: zero acts as one, clamp to the mode limit
  always_comb begin
    if (mode_count_r == '0) begin
      modes_act = coo2hg_pkg::MC_W'(1);
    end else if (32'(mode_count_r) > NM) begin
      modes_act = coo2hg_pkg::MC_W'(NM);
    end else begin
      modes_act = mode_count_r;
    end
  end

  assign in_coord[0] = in_chan.coord0;
  assign in_coord[1] = in_chan.coord1;
  assign in_coord[2] = in_chan.coord2;
  assign in_coord[3] = in_chan.coord3;

  coo2hg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_free  (out_free),
    .res_valid (res_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  coo2hg_dp #(
    .MAX_NONZEROS   (MAX_NONZEROS),
    .MAX_HYPEREDGES (MAX_HYPEREDGES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .modes         (modes_act),
    .size          (size_r),
    .in_opcode     (in_chan.opcode),
    .in_coord      (in_coord),
    .in_read_index (in_chan.read_index),
    .res_value     (res_value),
    .res_status    (res_status)
  );

  // Output register
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.value  = out_value_r;
  assign out_chan.status = out_status_r;

  // Checks
  a_load_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_load |-> !stat.full)
    else $error("load stored into a full coordinate store");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request taken while another is in progress");

  a_commit_built: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> stat.built)
    else $error("build commit did not mark the structure built");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !out_free) |=> res_valid)
    else $error("pending result dropped before the output register took it");

endmodule

FILE: tb/tb_coo_to_hypergraph_csr.sv
// tb_coo_to_hypergraph_csr: self-checking testbench for the COO to hypergraph CSR
// builder. Depends on coo2hg_pkg, coo2hg_if and the coo_to_hypergraph_csr RTL.
`timescale 1ns / 100ps

module tb_coo_to_hypergraph_csr;

  localparam int NZ_MAX   = coo2hg_pkg::MAX_NONZEROS;
  localparam int MODE_MAX = coo2hg_pkg::MAX_MODES;
  localparam int HE_MAX   = coo2hg_pkg::MAX_HYPEREDGES;
  localparam int VW       = coo2hg_pkg::VALUE_W;

  typedef struct {
    coo2hg_pkg::op_t                  op;
    logic [9:0]                       coord[4];
    logic [coo2hg_pkg::IDX_W-1:0]     read_index;
  } request_t;

  typedef struct {
    logic [VW-1:0]       value;
    coo2hg_pkg::status_t status;
  } answer_t;

  // Scoreboard: keeps its own copy of the stores and predicts each answer
  class csr_scoreboard_t;
    logic [2:0]   mode_count;
    logic [10:0]  mode_size[4];
    logic [9:0]   coord_mem[NZ_MAX*MODE_MAX];
    int unsigned  offset_mem[HE_MAX+1];
    int unsigned  member_mem[NZ_MAX*MODE_MAX];
    int unsigned  nz_count;
    bit           built;
    int unsigned  built_edges;
    int unsigned  built_conns;
    answer_t      pending[$];
    int           errors;
    int           good_builds;

    function new();
      mode_count  = coo2hg_pkg::MODE_COUNT_RESET;
      foreach (mode_size[m]) mode_size[m] = '0;
      nz_count    = 0;
      built       = 0;
      built_edges = 0;
      built_conns = 0;
      errors      = 0;
      good_builds = 0;
    endfunction

    function int unsigned active_modes();
      int unsigned m;
      m = mode_count;
      if (m < 1) m = 1;
      if (m > MODE_MAX) m = MODE_MAX;
      return m;
    endfunction

    function coo2hg_pkg::status_t load_nonzero(request_t r);
      int unsigned nm;
      nm = active_modes();
      if (nz_count >= NZ_MAX) return coo2hg_pkg::ST_FULL;
      for (int m = 0; m < nm; m++)
        if (r.coord[m] >= mode_size[m]) return coo2hg_pkg::ST_COORD;
      for (int m = 0; m < MODE_MAX; m++) coord_mem[nz_count*MODE_MAX + m] = r.coord[m];
      nz_count++;
      built = 0;
      return coo2hg_pkg::ST_OK;
    endfunction

    // Counting sort: count members, shifted prefix sum, then scatter ids
    function coo2hg_pkg::status_t build_csr(output logic [VW-1:0] conns);
      int unsigned nm, total, base, e;
      int unsigned cursor[HE_MAX+1];
      nm = active_modes();
      total = 0;
      conns = '0;
      for (int m = 0; m < nm; m++) total += mode_size[m];
      built = 0;
      if (total > HE_MAX) return coo2hg_pkg::ST_TOO_MANY;
      for (int n = 0; n < nz_count; n++)
        for (int m = 0; m < nm; m++)
          if (coord_mem[n*MODE_MAX + m] >= mode_size[m]) return coo2hg_pkg::ST_COORD;
      for (int h = 0; h <= total; h++) offset_mem[h] = 0;
      base = 0;
      for (int m = 0; m < nm; m++) begin
        for (int n = 0; n < nz_count; n++)
          offset_mem[base + coord_mem[n*MODE_MAX + m] + 1]++;
        base += mode_size[m];
      end
      for (int h = 1; h <= total; h++) offset_mem[h] += offset_mem[h-1];
      for (int h = 0; h < total; h++) cursor[h] = offset_mem[h];
      base = 0;
      for (int m = 0; m < nm; m++) begin
        for (int n = 0; n < nz_count; n++) begin
          e = base + coord_mem[n*MODE_MAX + m];
          member_mem[cursor[e]] = n;
          cursor[e]++;
        end
        base += mode_size[m];
      end
      built_edges = total;
      built_conns = nz_count * nm;
      built = 1;
      good_builds++;
      conns = VW'(built_conns);
      return coo2hg_pkg::ST_OK;
    endfunction

    function void note_request(request_t r);
      answer_t a;
      a.value  = '0;
      a.status = coo2hg_pkg::ST_OK;
      case (r.op)
        coo2hg_pkg::OP_LOAD:  a.status = load_nonzero(r);
        coo2hg_pkg::OP_BUILD: a.status = build_csr(a.value);
        coo2hg_pkg::OP_RD_OFF: begin
          if (built && r.read_index <= built_edges)
            a.value = VW'(offset_mem[r.read_index]);
          else a.status = coo2hg_pkg::ST_BAD_READ;
        end
        default: begin
          if (built && r.read_index < built_conns)
            a.value = VW'(member_mem[r.read_index]);
          else a.status = coo2hg_pkg::ST_BAD_READ;
        end
      endcase
      pending.push_back(a);
    endfunction

    function void check_result(logic [VW-1:0] value,
                               logic [coo2hg_pkg::STATUS_W-1:0] status);
      answer_t a;
      if (pending.size() == 0) begin
        $error("unexpected result: value %0d status %0d", value, status);
        errors++;
        return;
      end
      a = pending.pop_front();
      if (value !== a.value) begin
        $error("value: expected %0d, got %0d", a.value, value);
        errors++;
      end
      if (status !== a.status) begin
        $error("status: expected %0d, got %0d", a.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [coo2hg_pkg::PADDR_W-1:0] paddr;
  logic [coo2hg_pkg::PDATA_W-1:0] pwdata, prdata;
  logic        pready;
  int          idle_pct;
  int          sent;

  coo2hg_in_if  in_chan();
  coo2hg_out_if out_chan();
  csr_scoreboard_t sb;

  coo_to_hypergraph_csr dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random back-pressure, check on every accepted result
  always @(negedge clk) out_chan.ready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk)
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.value, out_chan.status);

  // Register write: setup then access phase
  task automatic write_reg(logic [coo2hg_pkg::REGIDX_W-1:0] idx, int unsigned data);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= coo2hg_pkg::PADDR_W'(idx * 4); pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == coo2hg_pkg::REG_MODE_COUNT) sb.mode_count = data[2:0];
    else sb.mode_size[idx - 1] = data[10:0];
  endtask

  task automatic set_modes(int mc, int s0, int s1, int s2, int s3);
    write_reg(coo2hg_pkg::REG_MODE_COUNT, mc);
    write_reg(coo2hg_pkg::REG_MODE0_SIZE, s0);
    write_reg(coo2hg_pkg::REG_MODE1_SIZE, s1);
    write_reg(coo2hg_pkg::REG_MODE2_SIZE, s2);
    write_reg(coo2hg_pkg::REG_MODE3_SIZE, s3);
  endtask

  // Request side: optional gap, then hold valid until ready
  task automatic send(request_t r);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= r.op;
    in_chan.coord0     <= r.coord[0];
    in_chan.coord1     <= r.coord[1];
    in_chan.coord2     <= r.coord[2];
    in_chan.coord3     <= r.coord[3];
    in_chan.read_index <= r.read_index;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(r);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic request_t make_req(coo2hg_pkg::op_t op, int c0, int c1, int c2,
                                        int c3, int idx);
    request_t r;
    r.op = op;
    r.coord[0] = c0; r.coord[1] = c1; r.coord[2] = c2; r.coord[3] = c3;
    r.read_index = idx;
    return r;
  endfunction

  // Well-formed load: active coords within size, idle modes kept below 8 so
  // that later settings (all sizes at least 8) still accept them
  function automatic request_t good_load();
    request_t r;
    r = make_req(coo2hg_pkg::OP_LOAD, 0, 0, 0, 0, $urandom_range(4095));
    for (int m = 0; m < 4; m++)
      if (m < sb.active_modes()) r.coord[m] = $urandom_range(sb.mode_size[m] - 1);
      else r.coord[m] = $urandom_range(7);
    return r;
  endfunction

  function automatic request_t random_req();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r = make_req(coo2hg_pkg::OP_LOAD, $urandom_range(1023), $urandom_range(1023),
                 $urandom_range(1023), $urandom_range(1023), $urandom_range(4095));
    if (pick < 50) r = good_load();
    else if (pick < 55) r = r;
    else if (pick < 58) r.op = coo2hg_pkg::OP_BUILD;
    else if (pick < 79) begin
      r.op = coo2hg_pkg::OP_RD_OFF;
      if (sb.built && $urandom_range(9) != 0) r.read_index = $urandom_range(sb.built_edges);
    end else begin
      r.op = coo2hg_pkg::OP_RD_LIST;
      if (sb.built && sb.built_conns > 0 && $urandom_range(9) != 0)
        r.read_index = $urandom_range(sb.built_conns - 1);
    end
    return r;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send(random_req());
    send(make_req(coo2hg_pkg::OP_BUILD, 0, 0, 0, 0, 0));
    for (int i = 0; i < 6; i++) send(random_req());
    drain();
  endtask

  initial begin
    sb = new();
    sent = 0;
    idle_pct = 27;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_chan.valid = 1'b0; in_chan.opcode = coo2hg_pkg::OP_LOAD;
    in_chan.coord0 = '0; in_chan.coord1 = '0; in_chan.coord2 = '0; in_chan.coord3 = '0;
    in_chan.read_index = '0;
    out_chan.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reads before any build, zero sizes, empty build
    send(make_req(coo2hg_pkg::OP_RD_OFF, 0, 0, 0, 0, 0));
    send(make_req(coo2hg_pkg::OP_RD_LIST, 0, 0, 0, 0, 4095));
    send(make_req(coo2hg_pkg::OP_LOAD, 0, 0, 0, 0, 0));
    send(make_req(coo2hg_pkg::OP_BUILD, 0, 0, 0, 0, 0));
    send(make_req(coo2hg_pkg::OP_RD_OFF, 0, 0, 0, 0, 0));
    send(make_req(coo2hg_pkg::OP_RD_OFF, 0, 0, 0, 0, 1));
    send(make_req(coo2hg_pkg::OP_RD_LIST, 0, 0, 0, 0, 0));
    drain();

    // Mode count zero acts as one mode
    set_modes(0, 8, 8, 8, 8);
    send(make_req(coo2hg_pkg::OP_LOAD, 7, 1, 2, 3, 0));
    send(make_req(coo2hg_pkg::OP_LOAD, 0, 7, 7, 7, 0));
    send(make_req(coo2hg_pkg::OP_LOAD, 8, 0, 0, 0, 0));
    send(make_req(coo2hg_pkg::OP_BUILD, 0, 0, 0, 0, 0));
    send(make_req(coo2hg_pkg::OP_RD_OFF, 0, 0, 0, 0, 8));
    send(make_req(coo2hg_pkg::OP_RD_OFF, 0, 0, 0, 0, 9));
    send(make_req(coo2hg_pkg::OP_RD_LIST, 0, 0, 0, 0, 1));
    send(make_req(coo2hg_pkg::OP_RD_LIST, 0, 0, 0, 0, 2));
    // load after build drops the build
    send(make_req(coo2hg_pkg::OP_LOAD, 3, 3, 3, 3, 0));
    send(make_req(coo2hg_pkg::OP_RD_LIST, 0, 0, 0, 0, 0));
    drain();

    // Shrunk size fails the build; size sum too large; restored size fails on the 1023 load
    write_reg(coo2hg_pkg::REG_MODE0_SIZE, 1);
    send(make_req(coo2hg_pkg::OP_BUILD, 0, 0, 0, 0, 0));
    drain();
    set_modes(7, 1024, 8, 8, 8);
    send(make_req(coo2hg_pkg::OP_BUILD, 0, 0, 0, 0, 0));
    send(make_req(coo2hg_pkg::OP_LOAD, 1023, 7, 7, 7, 0));
    drain();
    write_reg(coo2hg_pkg::REG_MODE0_SIZE, 8);
    send(make_req(coo2hg_pkg::OP_BUILD, 0, 0, 0, 0, 0));
    drain();
    random_phase(110);

    set_modes(4, 8, 16, 32, 64);
    random_phase(110);
    set_modes(2, 1000, 24, 8, 8);
    idle_pct = 0;
    random_phase(110);
    idle_pct = 27;
    set_modes(5, 256, 256, 256, 256);
    random_phase(110);
    set_modes(1, 1024, 8, 8, 8);
    random_phase(110);
    set_modes(3, 512, 300, 212, 8);
    random_phase(110);

    // Four-mode build over everything held, then edge reads
    set_modes(4, 256, 256, 256, 256);
    send(make_req(coo2hg_pkg::OP_BUILD, 0, 0, 0, 0, 0));
    send(make_req(coo2hg_pkg::OP_RD_LIST, 0, 0, 0, 0, 4095));
    send(make_req(coo2hg_pkg::OP_RD_OFF, 0, 0, 0, 0, 1024));
    send(make_req(coo2hg_pkg::OP_RD_OFF, 0, 0, 0, 0, 1025));
    for (int i = 0; i < 20; i++) send(random_req());
    drain();

    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Requests sent: %0d, good builds: %0d, nonzeros held: %0d",
             sent, sb.good_builds, sb.nz_count);
    if (sb.errors == 0) $display("[coo_to_hypergraph_csr] OK");
    else $display("[coo_to_hypergraph_csr] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #30ms;
    $display("[coo_to_hypergraph_csr] ERROR");
    $finish;
  end

endmodule
